@@ hdl/assert_macros.svh @@
// Assertion macros used by the checked module of the time step limiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is applied.
`define CTSL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that also holds while reset is applied.
`define CTSL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ctsl_pkg.sv @@
// Shared types and constants of the CFL time step limiter.
package ctsl_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFL_W         = 8;
	localparam int LEN_W         = 32;
	localparam int VEL_W         = 32;
	localparam int FRAME_W       = 16;
	localparam int PROD_W        = CFL_W + LEN_W;
	localparam int NEXT_W        = FRAME_W + 1 + LEN_W;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_COURANT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd2;

	localparam logic [CFL_W-1:0] COURANT_RST      = 8'd1;
	localparam logic [LEN_W-1:0] CELL_LENGTH_RST  = 32'd65536;
	localparam logic [LEN_W-1:0] FRAME_PERIOD_RST = 32'd2185;

	typedef struct packed {
		logic load;       // input item accepted
		logic mul;        // form numerator and next frame time
		logic div_step;   // one quotient bit
		logic res_load;   // capture result into output register
	} ctsl_cmd_t;

	typedef struct packed {
		logic div_done;   // current step is the final quotient bit
	} ctsl_status_t;

endpackage

@@ hdl/cfl_time_step_limiter_unit.sv @@
// Top level of the CFL adaptive time step limiter.
//
// Velocity channel (vel_valid / vel_stall): one signed velocity per item. Items
// without last_sample only fold |velocity| into the running maximum, one per
// cycle unless stalled, and give no result. The last_sample item folds in its
// velocity and starts the step computation from current_time and frame_index.
// Result channel (res_valid / res_stall): one step_length / write_frame item
// per last item. The result sits in an output register, so velocity items of
// the next grid are taken while it waits for the receiver.
// Sequence: a last item passes MUL (numerator and next frame time), then DIV
// (restoring divider, one quotient bit per step over the FRAC_BITS + 40 bit
// numerator), then DONE, which loads the output register behind res_valid.
// vel_stall is high during that whole computation; it stays high further while
// a previous result is still stalled in the output register.
// Config channel (cfg_valid / cfg_ready): always ready; index 0 Courant number,
// 1 cell_length, 2 frame_period; other indexes are ignored.
// Reset: config registers return to 1, 65536 and 2185, the running maximum
// clears and both channels go idle. No clearing pass is needed.
module cfl_time_step_limiter_unit import ctsl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vel_valid,
	output logic                    vel_stall,
	input  logic signed [VEL_W-1:0] velocity,
	input  logic                    last_sample,
	input  logic [LEN_W-1:0]        current_time,
	input  logic [FRAME_W-1:0]      frame_index,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [LEN_W-1:0]        step_length,
	output logic                    write_frame,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [LEN_W-1:0]        cfg_data
);

	ctsl_cmd_t    cmd;
	ctsl_status_t status;

	// user sends config writes only while idle, unchecked; port never pushes back
	assign cfg_ready = 1'b1;

	ctsl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.vel_valid   (vel_valid),
		.vel_stall   (vel_stall),
		.last_sample (last_sample),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.cmd         (cmd)
	);

	ctsl_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.velocity     (velocity),
		.last_sample  (last_sample),
		.current_time (current_time),
		.frame_index  (frame_index),
		.step_length  (step_length),
		.write_frame  (write_frame)
	);

endmodule

@@ hdl/ctsl_dp.sv @@
// Datapath: running maximum, config registers, multipliers, divider, result register.
module ctsl_dp import ctsl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctsl_cmd_t               cmd,
	output ctsl_status_t            status,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [LEN_W-1:0]        cfg_data,
	input  logic signed [VEL_W-1:0] velocity,
	input  logic                    last_sample,
	input  logic [LEN_W-1:0]        current_time,
	input  logic [FRAME_W-1:0]      frame_index,
	output logic [LEN_W-1:0]        step_length,
	output logic                    write_frame
);

	localparam int NUM_W = PROD_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W);
	localparam int CMP_W = (NUM_W > NEXT_W) ? NUM_W : NEXT_W;

	logic [CFL_W-1:0]   cfl_q;
	logic [LEN_W-1:0]   cell_q;
	logic [LEN_W-1:0]   period_q;
	logic [VEL_W-1:0]   max_q;
	logic [VEL_W-1:0]   div_q;
	logic               inf_q;
	logic [LEN_W-1:0]   now_q;
	logic [FRAME_W-1:0] frame_q;
	logic [NEXT_W-1:0]  next_q;
	logic [NEXT_W-1:0]  gap_q;
	logic               late_q;
	logic [NUM_W-1:0]   num_q;
	logic [VEL_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [VEL_W-1:0]   mag;
	logic [VEL_W-1:0]   new_max;
	logic [PROD_W-1:0]  prod;
	logic [NEXT_W-1:0]  next_time;
	logic [VEL_W:0]     shifted;
	logic [VEL_W:0]     diff;
	logic               ge;
	logic               clamp;
	logic [LEN_W-1:0]   quot_sat;
	logic [LEN_W-1:0]   gap_sat;

	// magnitude of the most negative value wraps to 2^31, held exactly unsigned
	assign mag     = velocity[VEL_W-1] ? (VEL_W'(0) - VEL_W'(velocity)) : VEL_W'(velocity);
	assign new_max = (mag > max_q) ? mag : max_q;

	assign prod      = {{LEN_W{1'b0}}, cfl_q} * {{CFL_W{1'b0}}, cell_q};
	assign next_time = NEXT_W'({1'b0, frame_q} + {{FRAME_W{1'b0}}, 1'b1})
	                 * {{(FRAME_W+1){1'b0}}, period_q};

	// restoring division, one quotient bit a cycle
	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign ge      = shifted >= {1'b0, div_q};

	assign status.div_done = (cnt_q == CNT_W'(NUM_W - 1));

	assign clamp    = inf_q || late_q || (CMP_W'(num_q) > CMP_W'(gap_q));
	assign quot_sat = (|num_q[NUM_W-1:LEN_W]) ? '1 : num_q[LEN_W-1:0];
	assign gap_sat  = (|gap_q[NEXT_W-1:LEN_W]) ? '1 : gap_q[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfl_q    <= COURANT_RST;
			cell_q   <= CELL_LENGTH_RST;
			period_q <= FRAME_PERIOD_RST;
			max_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COURANT:      cfl_q    <= cfg_data[CFL_W-1:0];
					REG_CELL_LENGTH:  cell_q   <= cfg_data;
					REG_FRAME_PERIOD: period_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				max_q <= last_sample ? '0 : new_max;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && last_sample) begin
			div_q   <= new_max;
			inf_q   <= (new_max == '0);
			now_q   <= current_time;
			frame_q <= frame_index;
		end
		if (cmd.mul) begin
			next_q <= next_time;
			num_q  <= {prod, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			cnt_q  <= '0;
		end
		if (cmd.div_step) begin
			num_q  <= {num_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[VEL_W-1:0] : shifted[VEL_W-1:0];
			cnt_q  <= cnt_q + CNT_W'(1);
			// frame gap settles off the division path
			gap_q  <= next_q - NEXT_W'(now_q);
			late_q <= NEXT_W'(now_q) > next_q;
		end
		if (cmd.res_load) begin
			write_frame <= clamp;
			step_length <= clamp ? (late_q ? '0 : gap_sat) : quot_sat;
		end
	end

endmodule

@@ hdl/ctsl_ctrl.sv @@
// Controller: sequences accept, multiply, divide and result hand-off.
`include "assert_macros.svh"
module ctsl_ctrl import ctsl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vel_valid,
	output logic         vel_stall,
	input  logic         last_sample,
	output logic         res_valid,
	input  logic         res_stall,
	input  ctsl_status_t status,
	output ctsl_cmd_t    cmd
);

	typedef enum logic [1:0] {
		IDLE,
		MUL,
		DIV,
		DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign vel_stall = (state_q != IDLE);
	assign accept    = vel_valid && !vel_stall;
	assign out_free  = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;

	assign cmd.load     = accept;
	assign cmd.mul      = (state_q == MUL);
	assign cmd.div_step = (state_q == DIV);
	assign cmd.res_load = (state_q == DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: if (accept && last_sample) state_q <= MUL;
				MUL:  state_q <= DIV;
				DIV:  if (status.div_done) state_q <= DONE;
				DONE: if (out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CTSL_ASSERT(a_res_from_done, $rose(res_valid) |-> $past(state_q == DONE), "result without divide")
	`CTSL_ASSERT(a_div_exit, (state_q == DIV) |=> (state_q == DIV || state_q == DONE), "divide left early")
	`CTSL_ASSERT(a_done_holds, (state_q == DONE && out_valid_q && res_stall) |=> (state_q == DONE), "result overwritten")
	`CTSL_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (state_q == IDLE && !out_valid_q), "reset not idle")

endmodule
